>>> rtl/hrlt_pkg.sv
// Shared types and constants of the HTTP request-line tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package hrlt_pkg;

  localparam int OFS_W = 12;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_SPACE = 3'd1,
    CLS_QMARK = 3'd2,
    CLS_HASH  = 3'd3,
    CLS_EQ    = 3'd4,
    CLS_AMP   = 3'd5,
    CLS_CR    = 3'd6,
    CLS_LF    = 3'd7
  } byte_class_t;

  typedef enum logic [2:0] {
    KIND_METHOD   = 3'd0,
    KIND_PATH     = 3'd1,
    KIND_QUERY    = 3'd2,
    KIND_FRAGMENT = 3'd3,
    KIND_VERSION  = 3'd4,
    KIND_BAD      = 3'd5
  } token_kind_t;

  // One classified byte, passed from the front end to the parser.
  typedef struct packed {
    byte_class_t          cls;
    logic [OFS_W-1:0]     pos;
    logic                 over_limit;
    logic                 new_req;
  } hrlt_beat_t;

  // One token result.
  typedef struct packed {
    token_kind_t          kind;
    logic [OFS_W-1:0]     key_offset;
    logic [OFS_W-1:0]     key_length;
    logic [OFS_W-1:0]     value_offset;
    logic [OFS_W-1:0]     value_length;
  } hrlt_result_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    c = CLS_OTHER;
    if (b == CH_SPACE) c = CLS_SPACE;
    if (b == CH_QMARK) c = CLS_QMARK;
    if (b == CH_HASH)  c = CLS_HASH;
    if (b == CH_EQ)    c = CLS_EQ;
    if (b == CH_AMP)   c = CLS_AMP;
    if (b == CH_CR)    c = CLS_CR;
    if (b == CH_LF)    c = CLS_LF;
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hrlt_fifo.sv
// Small register-based first-in first-out queue with status flags.
`timescale 1ns / 1ps
`default_nettype none

module hrlt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hrlt_front.sv
// Front end: byte classification and request position counting.
`timescale 1ns / 1ps
`default_nettype none

module hrlt_front #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [7:0]          data_byte,
  input  wire logic                new_request,
  output hrlt_pkg::hrlt_beat_t     beat
);

  import hrlt_pkg::*;

  // Wide enough for the saturated limit and for a 12-bit offset.
  localparam int LIM_W = $clog2(MAX_LINE + 1);
  localparam int POS_W = (LIM_W > OFS_W) ? LIM_W : OFS_W;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] cur_pos;
  logic             over;

  // A new request restarts counting at this very byte.
  assign cur_pos = new_request ? '0 : pos_r;
  assign over    = (cur_pos >= POS_W'(MAX_LINE));

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = over ? cur_pos : cur_pos + 1'b1;
    end
  end

  always_comb begin
    beat.cls        = classify(data_byte);
    beat.pos        = cur_pos[OFS_W-1:0];
    beat.over_limit = over;
    beat.new_req    = new_request;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hrlt_back.sv
// Back end: request-line parsing state machine that produces token results.
`timescale 1ns / 1ps
`default_nettype none

module hrlt_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                beat_valid,
  input  wire hrlt_pkg::hrlt_beat_t beat,
  input  wire logic                res_full,
  output logic                     beat_pop,
  output logic                     res_push,
  output hrlt_pkg::hrlt_result_t   res
);

  import hrlt_pkg::*;

  typedef enum logic [13:0] {
    PH_METHOD     = 14'b00000000000001,
    PH_PATH_FIRST = 14'b00000000000010,
    PH_PATH       = 14'b00000000000100,
    PH_QUERY      = 14'b00000000001000,
    PH_KEY        = 14'b00000000010000,
    PH_VAL_FIRST  = 14'b00000000100000,
    PH_VAL        = 14'b00000001000000,
    PH_FRAG_FIRST = 14'b00000010000000,
    PH_FRAG       = 14'b00000100000000,
    PH_VER_FIRST  = 14'b00001000000000,
    PH_VER        = 14'b00010000000000,
    PH_VER_CR     = 14'b00100000000000,
    PH_DONE       = 14'b01000000000000,
    PH_BAD        = 14'b10000000000000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [OFS_W-1:0] tok_start_r, tok_start_nxt;
  logic [OFS_W-1:0] key_start_r, key_start_nxt;
  logic [OFS_W-1:0] key_len_r, key_len_nxt;
  phase_t           ph;
  logic [OFS_W-1:0] ts;
  logic [OFS_W-1:0] ks;
  logic [OFS_W-1:0] kl;
  logic [OFS_W-1:0] p;
  logic             emit;
  logic             is_crlf;

  // A byte moves on only when the result queue has room, whether or not it makes a result.
  assign beat_pop = beat_valid && !res_full;
  assign res_push = beat_pop && emit;

  // A byte flagged as the start of a request sees freshly reset state.
  assign ph      = beat.new_req ? PH_METHOD : phase_r;
  assign ts      = beat.new_req ? '0 : tok_start_r;
  assign ks      = beat.new_req ? '0 : key_start_r;
  assign kl      = beat.new_req ? '0 : key_len_r;
  assign p       = beat.pos;
  assign is_crlf = (beat.cls == CLS_CR) || (beat.cls == CLS_LF);

  always_comb begin
    phase_nxt     = ph;
    tok_start_nxt = ts;
    key_start_nxt = ks;
    key_len_nxt   = kl;
    emit          = 1'b0;
    res           = '0;
    if (ph == PH_DONE || ph == PH_BAD) begin
      emit = 1'b0;
    end else if (beat.over_limit) begin
      phase_nxt      = PH_BAD;
      emit           = 1'b1;
      res.kind       = KIND_BAD;
      res.key_offset = p;
    end else begin
      unique case (ph)
        PH_METHOD: begin
          if (beat.cls == CLS_SPACE) begin
            emit           = 1'b1;
            res.kind       = KIND_METHOD;
            res.key_offset = ts;
            res.key_length = p - ts;
            phase_nxt      = PH_PATH_FIRST;
          end
        end
        PH_PATH_FIRST: begin
          tok_start_nxt = p;
          phase_nxt     = PH_PATH;
        end
        PH_PATH: begin
          if (beat.cls == CLS_SPACE || beat.cls == CLS_QMARK || beat.cls == CLS_HASH) begin
            emit           = 1'b1;
            res.kind       = KIND_PATH;
            res.key_offset = ts;
            res.key_length = p - ts;
            phase_nxt      = (beat.cls == CLS_SPACE) ? PH_VER_FIRST :
                             (beat.cls == CLS_QMARK) ? PH_QUERY : PH_FRAG_FIRST;
          end
        end
        PH_QUERY: begin
          if (beat.cls == CLS_SPACE) begin
            phase_nxt = PH_VER_FIRST;
          end else if (beat.cls == CLS_HASH) begin
            phase_nxt = PH_FRAG_FIRST;
          end else begin
            key_start_nxt = p;
            phase_nxt     = PH_KEY;
          end
        end
        PH_KEY: begin
          if (is_crlf) begin
            phase_nxt      = PH_BAD;
            emit           = 1'b1;
            res.kind       = KIND_BAD;
            res.key_offset = p;
          end else if (beat.cls == CLS_EQ) begin
            key_len_nxt = p - ks;
            phase_nxt   = PH_VAL_FIRST;
          end
        end
        PH_VAL_FIRST: begin
          tok_start_nxt = p;
          phase_nxt     = PH_VAL;
        end
        PH_VAL: begin
          if (is_crlf) begin
            phase_nxt      = PH_BAD;
            emit           = 1'b1;
            res.kind       = KIND_BAD;
            res.key_offset = p;
          end else if (beat.cls == CLS_SPACE || beat.cls == CLS_AMP ||
                       beat.cls == CLS_HASH) begin
            emit             = 1'b1;
            res.kind         = KIND_QUERY;
            res.key_offset   = ks;
            res.key_length   = kl;
            res.value_offset = ts;
            res.value_length = p - ts;
            phase_nxt        = (beat.cls == CLS_SPACE) ? PH_VER_FIRST :
                               (beat.cls == CLS_AMP) ? PH_QUERY : PH_FRAG_FIRST;
          end
        end
        PH_FRAG_FIRST: begin
          tok_start_nxt = p;
          if (beat.cls == CLS_SPACE) begin
            emit           = 1'b1;
            res.kind       = KIND_FRAGMENT;
            res.key_offset = p;
            phase_nxt      = PH_VER_FIRST;
          end else begin
            phase_nxt = PH_FRAG;
          end
        end
        PH_FRAG: begin
          if (is_crlf) begin
            phase_nxt      = PH_BAD;
            emit           = 1'b1;
            res.kind       = KIND_BAD;
            res.key_offset = p;
          end else if (beat.cls == CLS_SPACE) begin
            emit           = 1'b1;
            res.kind       = KIND_FRAGMENT;
            res.key_offset = ts;
            res.key_length = p - ts;
            phase_nxt      = PH_VER_FIRST;
          end
        end
        PH_VER_FIRST: begin
          tok_start_nxt = p;
          phase_nxt     = PH_VER;
        end
        PH_VER: begin
          if (beat.cls == CLS_CR) begin
            phase_nxt = PH_VER_CR;
          end
        end
        PH_VER_CR: begin
          emit = 1'b1;
          if (beat.cls == CLS_LF) begin
            res.kind       = KIND_VERSION;
            res.key_offset = ts;
            res.key_length = p - 1'b1 - ts;
            phase_nxt      = PH_DONE;
          end else begin
            res.kind       = KIND_BAD;
            res.key_offset = p;
            phase_nxt      = PH_BAD;
          end
        end
        default: begin
          phase_nxt = PH_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_METHOD;
      tok_start_r <= '0;
      key_start_r <= '0;
      key_len_r   <= '0;
    end else if (beat_pop) begin
      phase_r     <= phase_nxt;
      tok_start_r <= tok_start_nxt;
      key_start_r <= key_start_nxt;
      key_len_r   <= key_len_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/http_request_line_tokenizer.sv
// Top level of the HTTP request-line tokenizer: front end, byte queue, parser, result queue.
// Throughput: one byte per cycle sustained while the result queue has room, limited by the single parser step per byte.
// Path: the byte that ends a token is held in the byte queue; the parser then writes
// the token's result into the result queue, from which it is offered.
// Reset: synchronous, active low; both queues are emptied, the position counter is cleared
// and the parser returns to the method phase.
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_tokenizer #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_new_request,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_token_kind,
  output logic [11:0]      out_key_offset,
  output logic [11:0]      out_key_length,
  output logic [11:0]      out_value_offset,
  output logic [11:0]      out_value_length
);

  import hrlt_pkg::*;

  localparam int BEAT_W = $bits(hrlt_beat_t);
  localparam int RES_W  = $bits(hrlt_result_t);

  logic              in_accept;
  hrlt_beat_t        front_beat;
  logic [BEAT_W-1:0] beat_rd_data;
  logic              beat_empty;
  logic              beat_pop;
  hrlt_beat_t        back_beat;
  hrlt_result_t      back_res;
  logic              res_push;
  logic              res_full;
  logic [RES_W-1:0]  res_rd_data;
  hrlt_result_t      out_res;

  // A beat is taken whenever the byte queue has room; the result side stalls on its own.
  assign in_accept = in_push && !in_full;

  // The front end tags each byte with its class and its offset in the request. Its
  // counter runs on while the parser ignores bytes after the line ends, which is
  // harmless because the next request start clears it again.
  hrlt_front #(
    .MAX_LINE   (MAX_LINE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .data_byte  (in_data_byte),
    .new_request(in_new_request),
    .beat       (front_beat)
  );

  // The byte queue decouples the front end from the parser, so an input beat is accepted
  // while the byte queue has room, even when the parser stalls on a full result queue.
  hrlt_fifo #(
    .WIDTH  (BEAT_W),
    .DEPTH  (2)
  ) u_beat_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .wr_data(front_beat),
    .pop    (beat_pop),
    .rd_data(beat_rd_data),
    .full   (in_full),
    .empty  (beat_empty)
  );

  assign back_beat = hrlt_beat_t'(beat_rd_data);

  // The parser takes one classified byte per cycle whenever the result queue has room.
  hrlt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_valid(!beat_empty),
    .beat      (back_beat),
    .res_full  (res_full),
    .beat_pop  (beat_pop),
    .res_push  (res_push),
    .res       (back_res)
  );

  // Results wait here until they are popped; two entries keep the parser running at
  // full rate while the consumer pops every cycle.
  hrlt_fifo #(
    .WIDTH  (RES_W),
    .DEPTH  (2)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(back_res),
    .pop    (out_pop),
    .rd_data(res_rd_data),
    .full   (res_full),
    .empty  (out_empty)
  );

  assign out_res          = hrlt_result_t'(res_rd_data);
  assign out_token_kind   = out_res.kind;
  assign out_key_offset   = out_res.key_offset;
  assign out_key_length   = out_res.key_length;
  assign out_value_offset = out_res.value_offset;
  assign out_value_length = out_res.value_length;

  // The parser never produces a result into a full result queue.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // The parser only steps on a byte that is actually waiting.
  a_pop_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    beat_pop |-> !beat_empty)
    else $error("parser stepped with no byte queued");

  // A malformed result carries only the offending position.
  a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_token_kind == KIND_BAD) |->
      (out_key_length == '0 && out_value_offset == '0 && out_value_length == '0))
    else $error("malformed result with non-zero lengths");

  // Only query pairs carry a value part.
  a_value_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_token_kind != KIND_QUERY) |->
      (out_value_offset == '0 && out_value_length == '0))
    else $error("value fields set on a non-query result");

  // Straight after reset no result is offered.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

endmodule

`default_nettype wire
